[rtl/core/bda_pkg.sv]
package bda_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int RUN_WIDTH   = 16;

    localparam int DEBOUNCE_W  = 16;
    localparam int THRESH_W    = 8;
    localparam int CMP_W       = (RUN_WIDTH > DEBOUNCE_W) ? RUN_WIDTH : DEBOUNCE_W;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int S_TDATA_W   = ((NUM_BUTTONS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * NUM_BUTTONS + 7) / 8) * 8;

    localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_RST = DEBOUNCE_W'(1000);
    localparam logic [THRESH_W-1:0]    THRESH_RST   = THRESH_W'(30);
    localparam logic [NUM_BUTTONS-1:0] NO_REP_RST   = NUM_BUTTONS'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_NO_REPEAT  = 2'd2
    } t_cfg_idx;

    // Settings shared by every button channel
    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_count;
        logic [THRESH_W-1:0]   long_press_threshold;
    } t_btn_cfg;

    // Per-button update result for the current item
    typedef struct packed {
        logic fire;
        logic held;
    } t_btn_out;

endpackage

[rtl/core/button_debounce_autorepeat_top.sv]
// Debouncer with auto-repeat for active-low push buttons. Each input item is one
// sample of the raw lines; each gives exactly one result item with the event mask
// (bits [2:0], a press or repeat on this sample) and the debounced held flags
// (bits [5:3]). A level is accepted after debounce_count consecutive samples
// (zero acts as one); after long_press_threshold further held periods, each
// period fires a repeat event unless the button is in no_repeat_mask. The block
// takes one item every cycle unless tready is held low: an input register feeds
// one pass of per-button counter logic into a result register, which stalls
// only on tready low. Configuration is written through a plain write port while
// the block is idle; the user must keep to this, the block does not enforce it.
module button_debounce_autorepeat_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bda_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [2:0] buttons_n
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bda_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [2:0] event_mask, [5:3] held_flags
    input  logic                            i_cfg_wr_en,
    input  logic [bda_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bda_pkg::*;

    logic [DEBOUNCE_W-1:0]  r_debounce_count;
    logic [THRESH_W-1:0]    r_long_press_threshold;
    logic [NUM_BUTTONS-1:0] r_no_repeat_mask;

    logic                   r_in_valid;
    logic [NUM_BUTTONS-1:0] r_in_lines;
    logic                   r_out_valid;
    logic [NUM_BUTTONS-1:0] r_out_events;
    logic [NUM_BUTTONS-1:0] r_out_held;

    logic                   advance;
    t_btn_cfg               btn_cfg;
    t_btn_out               btn_res [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] n_events;
    logic [NUM_BUTTONS-1:0] n_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_count       <= DEBOUNCE_RST;
            r_long_press_threshold <= THRESH_RST;
            r_no_repeat_mask       <= NO_REP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:   r_debounce_count       <= i_cfg_data[DEBOUNCE_W-1:0];
                CFG_LONG_PRESS: r_long_press_threshold <= i_cfg_data[THRESH_W-1:0];
                CFG_NO_REPEAT:  r_no_repeat_mask       <= i_cfg_data[NUM_BUTTONS-1:0];
                default: ;
            endcase
        end
    end

    assign btn_cfg.debounce_count       = r_debounce_count;
    assign btn_cfg.long_press_threshold = r_long_press_threshold;

    // item moves from the input register to the result register
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_lines <= s_axis_tdata[NUM_BUTTONS-1:0];
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
        bda_button u_btn (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_advance   (advance),
            .i_line_n    (r_in_lines[g]),
            .i_no_repeat (r_no_repeat_mask[g]),
            .i_cfg       (btn_cfg),
            .o_result    (btn_res[g])
        );
        assign n_events[g] = btn_res[g].fire;
        assign n_held[g]   = btn_res[g].held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_events <= n_events;
            r_out_held   <= n_held;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_held, r_out_events});

    // an event can only come from a button that is held after the sample
    a_event_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_events & ~r_out_held) == '0))
        else $error("event on a button that is not held");

    // empty result register never blocks the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // a buffered item always reaches the result register next cycle when it is free
    a_item_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("item lost between input and result register");

endmodule

[rtl/core/bda_button.sv]
module bda_button (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_line_n,
    input  logic               i_no_repeat,
    input  bda_pkg::t_btn_cfg  i_cfg,
    output bda_pkg::t_btn_out  o_result
);
    import bda_pkg::*;

    localparam logic [RUN_WIDTH-1:0] RUN_MAX  = '1;
    localparam logic [THRESH_W-1:0]  HOLD_MAX = '1;

    logic [RUN_WIDTH-1:0] r_press_run, n_press_run;
    logic [RUN_WIDTH-1:0] r_release_run, n_release_run;
    logic                 r_held, n_held;
    logic [THRESH_W-1:0]  r_hold, n_hold;

    logic [RUN_WIDTH-1:0] press_inc, release_inc;
    logic [THRESH_W-1:0]  hold_inc;
    logic                 press_done, release_done;
    logic                 fire;

    assign press_inc    = (r_press_run == RUN_MAX) ? RUN_MAX : r_press_run + 1'b1;
    assign release_inc  = (r_release_run == RUN_MAX) ? RUN_MAX : r_release_run + 1'b1;
    assign hold_inc     = (r_hold == HOLD_MAX) ? HOLD_MAX : r_hold + 1'b1;
    assign press_done   = CMP_W'(press_inc) >= CMP_W'(i_cfg.debounce_count);
    assign release_done = CMP_W'(release_inc) >= CMP_W'(i_cfg.debounce_count);

    always_comb begin
        n_press_run   = r_press_run;
        n_release_run = r_release_run;
        n_held        = r_held;
        n_hold        = r_hold;
        fire          = 1'b0;
        if (!i_line_n) begin
            n_press_run   = press_inc;
            n_release_run = '0;
            if (press_done) begin
                n_press_run = '0;
                if (!r_held) begin
                    n_held = 1'b1;
                    n_hold = '0;
                    fire   = 1'b1;
                end else if (!i_no_repeat) begin
                    // pin at threshold once reached, fire on that period and each one after
                    if (hold_inc >= i_cfg.long_press_threshold) begin
                        n_hold = i_cfg.long_press_threshold;
                        fire   = 1'b1;
                    end else begin
                        n_hold = hold_inc;
                    end
                end
            end
        end else begin
            n_release_run = release_inc;
            n_press_run   = '0;
            if (release_done) begin
                n_held        = 1'b0;
                n_release_run = '0;
            end
        end
    end

    assign o_result.fire = fire;
    assign o_result.held = n_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_run   <= '0;
            r_release_run <= '0;
            r_held        <= 1'b0;
            r_hold        <= '0;
        end else if (i_advance) begin
            r_press_run   <= n_press_run;
            r_release_run <= n_release_run;
            r_held        <= n_held;
            r_hold        <= n_hold;
        end
    end

endmodule

[tb/sv/button_debounce_autorepeat_top_tb.sv]
`timescale 1ns / 1ps

module button_debounce_autorepeat_top_tb;
    import bda_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 4;     // idle cycles before a register write
    localparam int LONG_HOLD   = 60;

    typedef enum {OP_SAMPLE, OP_REG_WRITE} t_stim_kind;

    typedef struct {
        t_stim_kind            kind;
        logic [2:0]            lines;
        int                    gap;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_stim_op;

    typedef struct packed {
        logic [2:0] held;
        logic [2:0] events;
    } t_btn_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;   // [2:0] buttons_n
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;        // [2:0] event_mask, [5:3] held_flags
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    t_stim_op    pending_ops[$];
    t_btn_result expected_results[$];

    // debouncer state mirror
    logic [DEBOUNCE_W-1:0] deb_count;
    logic [THRESH_W-1:0]   long_thr;
    logic [2:0]            rep_mask;
    logic [15:0]           press_run [3];
    logic [15:0]           release_run [3];
    logic                  held [3];
    logic [7:0]            hold_periods [3];

    int errors = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int quiet = 0;
    int rx_wait = 0;

    button_debounce_autorepeat_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    task automatic clear_debouncer();
        deb_count = DEBOUNCE_RST;
        long_thr  = THRESH_RST;
        rep_mask  = NO_REP_RST;
        for (int b = 0; b < 3; b++) begin
            press_run[b]    = '0;
            release_run[b]  = '0;
            held[b]         = 1'b0;
            hold_periods[b] = '0;
        end
    endtask

    task automatic apply_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DEBOUNCE:   deb_count = data[DEBOUNCE_W-1:0];
            CFG_LONG_PRESS: long_thr  = data[THRESH_W-1:0];
            CFG_NO_REPEAT:  rep_mask  = data[2:0];
            default: ;
        endcase
    endtask

    task automatic predict_sample(input logic [2:0] lines, output t_btn_result r);
        int h;
        r = '0;
        for (int b = 0; b < 3; b++) begin
            if (!lines[b]) begin
                if (press_run[b] != 16'hFFFF) press_run[b] = press_run[b] + 16'd1;
                release_run[b] = '0;
                if (press_run[b] >= deb_count) begin
                    if (held[b]) begin
                        if (!rep_mask[b]) begin
                            h = hold_periods[b];
                            h = (h >= 255) ? 255 : h + 1;
                            if (h >= long_thr) begin
                                h = long_thr;
                                r.events[b] = 1'b1;
                            end
                            hold_periods[b] = h[7:0];
                        end
                    end else begin
                        held[b]         = 1'b1;
                        hold_periods[b] = '0;
                        r.events[b]     = 1'b1;
                    end
                    press_run[b] = '0;
                end
            end else begin
                if (release_run[b] != 16'hFFFF) release_run[b] = release_run[b] + 16'd1;
                press_run[b] = '0;
                if (release_run[b] >= deb_count) begin
                    held[b]        = 1'b0;
                    release_run[b] = '0;
                end
            end
            r.held[b] = held[b];
        end
    endtask

    task automatic report(input string what, input logic [2:0] want, input logic [2:0] got);
        errors++;
        $display("%0t: %s mismatch: expected %b, got %b", $time, what, want, got);
    endtask

    task automatic push_sample(input logic [2:0] lines, input bit fast);
        t_stim_op op;
        op.kind  = OP_SAMPLE;
        op.lines = lines;
        op.gap   = fast ? 0 : $urandom_range(0, 9);
        op.idx   = CFG_DEBOUNCE;
        op.data  = '0;
        pending_ops.push_back(op);
    endtask

    // high bits of the narrow registers carry noise; the block ignores them
    task automatic push_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        t_stim_op op;
        op.kind  = OP_REG_WRITE;
        op.lines = '0;
        op.gap   = 0;
        op.idx   = idx;
        case (idx)
            CFG_LONG_PRESS: op.data = {8'($urandom), value[7:0]};
            CFG_NO_REPEAT:  op.data = {13'($urandom), value[2:0]};
            default:        op.data = value;
        endcase
        pending_ops.push_back(op);
    endtask

    task automatic push_run(input logic [2:0] lines, input int n);
        for (int i = 0; i < n; i++) push_sample(lines, 1'b0);
    endtask

    // one setting, then held patterns with bounce, plus bursts of pure noise
    task automatic add_phase(input logic [15:0] deb, input logic [7:0] thr,
                             input logic [2:0] mask, input int n_items);
        bit         fast;
        int         count;
        int         len;
        int         span;
        logic [2:0] target;
        logic [2:0] s;
        fast = ($urandom_range(0, 3) == 0);
        push_reg(CFG_DEBOUNCE, deb);
        push_reg(CFG_LONG_PRESS, 16'(thr));
        push_reg(CFG_NO_REPEAT, 16'(mask));
        count = 0;
        while (count < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) push_sample(3'($urandom_range(0, 7)), fast);
            end else begin
                target = 3'($urandom_range(0, 7));
                span   = ((deb == 0) ? 1 : int'(deb)) * (int'(thr) + 3);
                if (span > 80) span = 80;
                len = $urandom_range(1, span);
                for (int i = 0; i < len; i++) begin
                    s = target;
                    if ($urandom_range(0, 11) == 0) s[$urandom_range(0, 2)] = ~s[$urandom_range(0, 2)];
                    push_sample(s, fast);
                end
            end
            count += len;
        end
    endtask

    // sender: pops the pending queue, predicts on each accepted item
    always @(posedge i_clk) begin : drive_proc
        logic                 nxt_valid;
        logic [S_TDATA_W-1:0] nxt_data;
        logic                 nxt_we;
        t_stim_op             op;
        t_btn_result          res;
        if (!i_rst_n) begin
            clear_debouncer();
            s_axis_tvalid <= 1'b0;
            i_cfg_wr_en   <= 1'b0;
            gap_left = 0;
            quiet    = 0;
        end else begin
            nxt_valid = s_axis_tvalid;
            nxt_data  = s_axis_tdata;
            nxt_we    = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_sample(s_axis_tdata[2:0], res);
                expected_results.push_back(res);
                nxt_valid = 1'b0;
            end
            quiet = (expected_results.size() == 0 && !s_axis_tvalid) ? quiet + 1 : 0;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() != 0) begin
                    op = pending_ops[0];
                    if (op.kind == OP_SAMPLE) begin
                        nxt_valid = 1'b1;
                        nxt_data  = S_TDATA_W'(op.lines);
                        gap_left  = op.gap;
                        void'(pending_ops.pop_front());
                    end else if (quiet >= SETTLE) begin
                        nxt_we = 1'b1;
                        i_cfg_index <= op.idx;
                        i_cfg_data  <= op.data;
                        apply_reg(op.idx, op.data);
                        void'(pending_ops.pop_front());
                    end
                end
            end
            s_axis_tvalid <= nxt_valid;
            s_axis_tdata  <= nxt_data;
            i_cfg_wr_en   <= nxt_we;
        end
    end

    // receiver: random stalls, stall-free stretches, a few long hold-offs
    always @(posedge i_clk) begin : monitor_proc
        t_btn_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: expected none, got %h",
                             $time, m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[2:0] !== want.events)
                        report("event_mask", want.events, m_axis_tdata[2:0]);
                    if (m_axis_tdata[5:3] !== want.held)
                        report("held_flags", want.held, m_axis_tdata[5:3]);
                end
                results_seen++;
                if (results_seen == 400 || results_seen == 1000 || results_seen == 1400)
                    rx_wait = LONG_HOLD;
                else if ((results_seen / 150) % 3 == 0)
                    rx_wait = 0;
                else
                    rx_wait = $urandom_range(0, 9);
            end
            m_axis_tready <= (rx_wait == 0);
            if (rx_wait > 0) rx_wait--;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("** button_debounce_autorepeat_top: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [15:0] deb;
        logic [7:0]  thr;
        int          r;

        // reset values: debounce of 1000 accepts nothing here
        push_sample(3'b111, 1'b0);
        push_sample(3'b000, 1'b0);
        push_sample(3'b101, 1'b0);

        // debounce 1, threshold 1: press then repeat every sample
        push_reg(CFG_DEBOUNCE, 16'd1);
        push_reg(CFG_LONG_PRESS, 16'd1);
        push_reg(CFG_NO_REPEAT, 16'd0);
        push_sample(3'b111, 1'b0);
        push_run(3'b000, 3);
        push_sample(3'b111, 1'b0);
        push_sample(3'b110, 1'b0);
        push_sample(3'b101, 1'b0);
        push_sample(3'b011, 1'b0);

        // zero debounce acts as one; all masked, then unmasked, with zero threshold
        push_reg(CFG_DEBOUNCE, 16'd0);
        push_reg(CFG_LONG_PRESS, 16'd0);
        push_reg(CFG_NO_REPEAT, 16'd7);
        push_sample(3'b111, 1'b0);
        push_run(3'b000, 2);
        push_reg(CFG_NO_REPEAT, 16'd0);
        push_run(3'b000, 2);

        // threshold lowered while held pins the counter to it
        push_reg(CFG_DEBOUNCE, 16'd2);
        push_reg(CFG_LONG_PRESS, 16'd10);
        push_reg(CFG_NO_REPEAT, 16'b010);
        push_run(3'b111, 2);
        push_run(3'b000, 8);
        push_reg(CFG_LONG_PRESS, 16'd2);
        push_run(3'b000, 2);
        push_run(3'b111, 2);

        // largest threshold: hold counter climbs to 255 and stays
        push_reg(CFG_DEBOUNCE, 16'd1);
        push_reg(CFG_LONG_PRESS, 16'd255);
        push_reg(CFG_NO_REPEAT, 16'b100);
        for (int i = 0; i < 262; i++) push_sample(3'b000, (i % 50) < 25);
        push_run(3'b111, 3);

        for (int p = 0; p < 11; p++) begin
            r = $urandom_range(0, 9);
            if (r == 0)      deb = 16'd0;
            else if (r <= 6) deb = 16'($urandom_range(1, 4));
            else if (r <= 8) deb = 16'($urandom_range(5, 12));
            else             deb = 16'($urandom_range(13, 40));
            r = $urandom_range(0, 9);
            if (r == 0)      thr = 8'd0;
            else if (r <= 8) thr = 8'($urandom_range(1, 5));
            else             thr = 8'($urandom_range(6, 255));
            add_phase(deb, thr, 3'($urandom_range(0, 7)), 120);
        end

        // largest debounce count: nothing gets accepted in a short run
        add_phase(16'hFFFF, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 20);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0)
            $display("** button_debounce_autorepeat_top: PASSED **");
        else
            $display("** button_debounce_autorepeat_top: FAILED **");
        $finish;
    end

endmodule

[button_debounce_autorepeat_top.f]
rtl/core/bda_pkg.sv
rtl/core/bda_button.sv
rtl/core/button_debounce_autorepeat_top.sv
tb/sv/button_debounce_autorepeat_top_tb.sv
